// ===== src/lfo_auto_panner_top_defines.svh =====
// assertion macros for the auto-panner
`ifndef LFO_AUTO_PANNER_TOP_DEFINES_SVH
`define LFO_AUTO_PANNER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LAP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LAP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LAP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/lap_pkg.sv =====
package lap_pkg;
   localparam int SineTableDepth = 256;
   localparam int TabBits = $clog2(SineTableDepth);
   localparam logic signed [18:0] ONE_Q16 = 19'sd65536;

   typedef enum logic [2:0] {
      CSR_PHASE_STEP = 3'd0,
      CSR_PAN_DEPTH  = 3'd1,
      CSR_PAN_CENTER = 3'd2,
      CSR_PAN_WIDTH  = 3'd3,
      CSR_WAVEFORM   = 3'd4,
      CSR_PHASE_OFS  = 3'd5,
      CSR_SMOOTH     = 3'd6,
      CSR_FADE_LEN   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [23:0] left_sample;
      logic signed [23:0] right_sample;
      logic               first_of_frame;
   } req_payload_type;

   typedef struct packed {
      logic signed [23:0] left_out;
      logic signed [23:0] right_out;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PREP, ST_DIV_GO, ST_DIV_WAIT, ST_GATE, ST_LFO, ST_LFO_W, ST_PAN,
      ST_PAN_CLAMP, ST_SIN_A, ST_SIN_B, ST_COS_A, ST_COS_B, ST_TL, ST_TR,
      ST_SL, ST_SR, ST_GL, ST_GR, ST_OUT_L, ST_OUT_R, ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic prep;
      logic div_start;
      state_type step;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic div_busy;
      logic rsp_full;
   } status_type;

   // series sine rounded to Q16 for i*(pi/2)/depth
   function automatic logic [16:0] series_sine(input logic [63:0] x);
      logic [63:0] x2, term;
      logic signed [63:0] sum;
      logic [63:0] r;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      r = (64'(sum) + 64'd8192) >> 14;
      return (r > 64'd65536) ? 17'd65536 : r[16:0];
   endfunction

   function automatic logic [16:0] quarter_entry(input logic [TabBits:0] i);
      return series_sine(64'd1686629713 * 64'(i) / 64'(SineTableDepth));
   endfunction
endpackage

// ===== src/lap_divider.sv =====
// unsigned restoring divider, one quotient bit per cycle
module lap_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [29:0] dividend,
   input  logic [12:0] divisor,
   output logic        busy,
   output logic [29:0] quotient
);
   logic [29:0] quot_ff, quot_in;
   logic [13:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [12:0] dsr_ff, dsr_in;
   logic [13:0] trial;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff[12:0], quot_ff[29]};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = 5'd30;
         busy_in = 1'b1;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = trial - {1'b0, dsr_ff};
            quot_in = {quot_ff[28:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[28:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;
endmodule

// ===== src/lap_ctrl.sv =====
// sequencer for one pair
module lap_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lap_pkg::status_type status,
   output lap_pkg::cmd_type    cmd
);
   import lap_pkg::*;
   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_PREP;
         ST_PREP:      state_in = status.first ? ST_DIV_GO : ST_DONE;
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (!status.div_busy) state_in = ST_GATE;
         ST_GATE:      state_in = ST_LFO;
         ST_LFO:       state_in = ST_LFO_W;
         ST_LFO_W:     state_in = ST_PAN;
         ST_PAN:       state_in = ST_PAN_CLAMP;
         ST_PAN_CLAMP: state_in = ST_SIN_A;
         ST_SIN_A:     state_in = ST_SIN_B;
         ST_SIN_B:     state_in = ST_COS_A;
         ST_COS_A:     state_in = ST_COS_B;
         ST_COS_B:     state_in = ST_TL;
         ST_TL:        state_in = ST_TR;
         ST_TR:        state_in = ST_SL;
         ST_SL:        state_in = ST_SR;
         ST_SR:        state_in = ST_GL;
         ST_GL:        state_in = ST_GR;
         ST_GR:        state_in = ST_DONE;
         // wait until the previous result beat has left
         ST_DONE:      if (!status.rsp_full) state_in = ST_OUT_L;
         ST_OUT_L:     state_in = ST_OUT_R;
         ST_OUT_R:     state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.load_req  = (state_ff == ST_IDLE) && req_valid;
      cmd.prep      = (state_ff == ST_PREP) && status.first;
      cmd.div_start = (state_ff == ST_DIV_GO);
      cmd.step      = state_ff;
      req_stall     = (state_ff != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ===== src/lap_datapath.sv =====
// frame state, shared multiplier and output register
module lap_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  lap_pkg::req_payload_type req_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_data,
   input  lap_pkg::cmd_type         cmd,
   output lap_pkg::status_type      status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lap_pkg::rsp_payload_type rsp_payload
);
   import lap_pkg::*;

   // config registers
   logic [30:0] phase_step_ff;
   logic [16:0] pan_depth_ff;
   logic signed [17:0] pan_center_ff, pan_width_ff;
   logic        wave_ff;
   logic [31:0] phase_offset_ff;
   logic [15:0] smooth_ff;
   logic [12:0] fade_len_ff;

   // frame state
   logic [31:0] phase_ff, phase_in, applied_ff, applied_in;
   logic signed [18:0] sm_l_ff, sm_r_ff, g_l_ff, g_r_ff;
   logic active_ff, active_in, pending_ff, pending_in, started_ff, started_in;
   logic signed [14:0] fpos_ff, fpos_in;
   logic fading_ff, fading_in, fade_out_ff, fade_out_in, fade_end_ff, fade_end_in;

   // work registers
   req_payload_type req_ff;
   logic [12:0] len_ff, len_in;
   logic signed [18:0] gate_ff, lfo_ff, pan_ff, sin_ff, cos_ff, tl_ff, tr_ff, tmp_ff;
   logic [30:0] frac_ff;
   logic [16:0] ta_ff, tb_ff;
   logic rsp_valid_ff;
   rsp_payload_type rsp_ff;

   // divider for the fade gate
   logic        div_busy;
   logic [29:0] div_q;
   logic [29:0] div_num;
   lap_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(div_num), .divisor(len_ff), .busy(div_busy), .quotient(div_q)
   );

   // quarter table
   logic [16:0] qtab [SineTableDepth + 1];
   always_comb begin
      for (int i = 0; i <= SineTableDepth; i++) qtab[i] = quarter_entry((TabBits + 1)'(i));
   end

   // quarter-sine helpers over frac_ff, frac in [0, 2^30]
   logic [TabBits+30:0] qpos;
   logic [TabBits:0]    qidx;
   logic [TabBits:0]    qnxt;
   logic [29:0]         qrem;
   logic                qsat;
   logic signed [47:0]  qfrac;
   logic signed [18:0]  qsin;
   always_comb begin
      qpos = (TabBits + 31)'(frac_ff) * (TabBits + 31)'(SineTableDepth);
      qidx = qpos[TabBits+30:30];
      qrem = qpos[29:0];
      qsat = (qidx >= (TabBits + 1)'(SineTableDepth));
      qnxt = qsat ? qidx : qidx + (TabBits + 1)'(1);
      qfrac = (48'(signed'({2'b0, qtab[qnxt]})) - 48'(signed'({2'b0, qtab[qidx]})))
              * 48'(signed'({18'b0, qrem}));
      qsin = signed'({2'b0, qtab[qidx]})
             + 19'((qfrac + ((qfrac < 0) ? 48'sh3FFF_FFFF : 48'sd0)) >>> 30);
   end

   // pan moved to [0, 2]
   logic signed [18:0] pan_u;
   assign pan_u = pan_ff + ONE_Q16;

   // shared multiplier
   logic signed [31:0] ma;
   logic signed [31:0] mb;
   logic signed [63:0] mprod;
   logic signed [47:0] q16;
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.step)
         ST_PAN:  begin ma = 32'(pan_width_ff); mb = 32'(lfo_ff); end
         ST_SIN_B, ST_COS_B: begin
            ma = 32'(signed'({1'b0, tb_ff}) - signed'({1'b0, ta_ff}));
            mb = signed'({2'b0, qrem});
         end
         ST_TL:   begin ma = 32'(tmp_ff); mb = 32'(cos_ff - ONE_Q16); end
         ST_TR:   begin ma = 32'(tmp_ff); mb = 32'(sin_ff - ONE_Q16); end
         ST_SL:   begin ma = 32'({1'b0, smooth_ff}); mb = 32'(tl_ff - sm_l_ff); end
         ST_SR:   begin ma = 32'({1'b0, smooth_ff}); mb = 32'(tr_ff - sm_r_ff); end
         ST_GL:   begin ma = 32'(gate_ff); mb = 32'(sm_l_ff - ONE_Q16); end
         ST_GR:   begin ma = 32'(gate_ff); mb = 32'(sm_r_ff - ONE_Q16); end
         ST_OUT_L: begin ma = 32'(req_ff.left_sample); mb = 32'(g_l_ff); end
         ST_OUT_R: begin ma = 32'(req_ff.right_sample); mb = 32'(g_r_ff); end
         default: begin ma = '0; mb = '0; end
      endcase
      mprod = ma * mb;
      q16 = 48'((mprod + ((mprod < 0) ? 64'sd65535 : 64'sd0)) >>> 16);
   end

   function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
      if (v > 48'sd8388607) return 24'sd8388607;
      if (v < -48'sd8388608) return -24'sd8388608;
      return v[23:0];
   endfunction

   function automatic logic signed [47:0] prod_div30(input logic signed [63:0] v);
      return 48'((v + ((v < 0) ? 64'sh3FFF_FFFF : 64'sd0)) >>> 30);
   endfunction

   // frame-start bookkeeping
   logic signed [14:0] p;
   logic [13:0] len2;
   always_comb begin
      phase_in   = phase_ff;
      applied_in = applied_ff;
      active_in  = active_ff;
      pending_in = pending_ff;
      started_in = started_ff;
      fpos_in    = fpos_ff;
      fading_in  = fading_ff;
      fade_out_in = fade_out_ff;
      fade_end_in = fade_end_ff;
      len_in = (fade_len_ff == 13'd0) ? 13'd1 :
               (fade_len_ff > 13'd4096) ? 13'd4096 : fade_len_ff;
      len2 = {len_in, 1'b0};
      p = '0;
      div_num = '0;
      if (cmd.prep) begin
         if (!started_ff) begin
            phase_in   = phase_offset_ff;
            applied_in = phase_offset_ff;
            active_in  = wave_ff;
            pending_in = wave_ff;
            started_in = 1'b1;
         end
         if (phase_offset_ff != applied_in) begin
            phase_in   = phase_in + (phase_offset_ff - applied_in);
            applied_in = phase_offset_ff;
         end
         if (wave_ff != pending_in) begin
            pending_in = wave_ff;
            if (fpos_ff < 0) fpos_in = '0;
         end else if (wave_ff != active_in && fpos_ff < 0) begin
            fpos_in = '0;
         end
         fading_in = 1'b0;
         fade_end_in = 1'b0;
         if (fpos_in >= 0) begin
            fading_in = 1'b1;
            p = fpos_in;
            fade_out_in = (p < signed'({2'b0, len_in}));
            if (p == signed'({2'b0, len_in})) active_in = pending_in;
            fpos_in = p + 15'sd1;
            if (fpos_in > signed'({1'b0, len2})) begin
               fade_end_in = 1'b1;
               fpos_in = (active_in != pending_in) ? 15'sd0 : -15'sd1;
            end
         end
      end
      // dividend from the registered position
      p = fpos_ff - 15'sd1;
      if (fade_end_ff) p = '0;
      else if (!fade_out_ff) p = p - signed'({2'b0, len_ff});
      if (fpos_ff == 15'sd0 && !fade_end_ff) p = signed'({2'b0, len_ff}) - 15'sd1;
      div_num = {p[13:0], 16'd0};
   end

   // main registers
   logic [31:0] d;
   always_comb d = phase_ff[31] ? (phase_ff - 32'h8000_0000) : (32'h8000_0000 - phase_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         pan_depth_ff    <= 17'd65536;
         pan_center_ff   <= '0;
         pan_width_ff    <= 18'sd65536;
         wave_ff         <= 1'b0;
         phase_offset_ff <= '0;
         smooth_ff       <= 16'd1000;
         fade_len_ff     <= 13'd120;
         phase_ff   <= '0;
         applied_ff <= '0;
         sm_l_ff    <= ONE_Q16;
         sm_r_ff    <= ONE_Q16;
         g_l_ff     <= ONE_Q16;
         g_r_ff     <= ONE_Q16;
         active_ff  <= 1'b0;
         pending_ff <= 1'b0;
         started_ff <= 1'b0;
         fpos_ff    <= -15'sd1;
         fading_ff  <= 1'b0;
         fade_out_ff <= 1'b0;
         fade_end_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PHASE_STEP: phase_step_ff   <= csr_data[30:0];
               CSR_PAN_DEPTH:  pan_depth_ff    <= csr_data[16:0];
               CSR_PAN_CENTER: pan_center_ff   <= csr_data[17:0];
               CSR_PAN_WIDTH:  pan_width_ff    <= csr_data[17:0];
               CSR_WAVEFORM:   wave_ff         <= csr_data[0];
               CSR_PHASE_OFS:  phase_offset_ff <= csr_data;
               CSR_SMOOTH:     smooth_ff       <= csr_data[15:0];
               CSR_FADE_LEN:   fade_len_ff     <= csr_data[12:0];
               default: ;
            endcase
         end
         if (cmd.prep) begin
            applied_ff  <= applied_in;
            active_ff   <= active_in;
            pending_ff  <= pending_in;
            started_ff  <= started_in;
            fpos_ff     <= fpos_in;
            fading_ff   <= fading_in;
            fade_out_ff <= fade_out_in;
            fade_end_ff <= fade_end_in;
            phase_ff    <= phase_in;
         end
         case (cmd.step)
            ST_SL: sm_l_ff <= sm_l_ff + 19'(q16);
            ST_SR: sm_r_ff <= sm_r_ff + 19'(q16);
            ST_GL: g_l_ff <= ONE_Q16 + 19'(q16);
            ST_GR: begin
               g_r_ff   <= ONE_Q16 + 19'(q16);
               phase_ff <= phase_ff + {1'b0, phase_step_ff};
            end
            default: ;
         endcase
         if (cmd.step == ST_OUT_R) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
      // work registers
      if (cmd.load_req) req_ff <= req_payload;
      if (cmd.prep) len_ff <= len_in;
      case (cmd.step)
         ST_GATE: begin
            if (!fading_ff || fade_end_ff) gate_ff <= ONE_Q16;
            else if (fade_out_ff) gate_ff <= ONE_Q16 - signed'({2'b0, div_q[16:0]});
            else gate_ff <= signed'({2'b0, div_q[16:0]});
         end
         ST_LFO: begin
            if (active_ff) lfo_ff <= ONE_Q16 - signed'({1'b0, d[31:14]});
            else frac_ff <= phase_ff[30] ? (31'h4000_0000 - {1'b0, phase_ff[29:0]})
                                         : {1'b0, phase_ff[29:0]};
            tmp_ff <= {1'b0, phase_ff[31:30], 16'd0};
         end
         // quarter sine of frac, negated in the second half turn
         ST_LFO_W: if (!active_ff) lfo_ff <= phase_ff[31] ? -qsin : qsin;
         ST_PAN: pan_ff <= 19'(q16 + 48'(pan_center_ff) > 48'sd65536 ? 48'sd65536 :
                               (q16 + 48'(pan_center_ff) < -48'sd65536 ? -48'sd65536 :
                                q16 + 48'(pan_center_ff)));
         ST_PAN_CLAMP: frac_ff <= {pan_u[17:0], 13'd0};
         ST_SIN_A: begin ta_ff <= qsat ? qtab[SineTableDepth] : qtab[qidx];
            tb_ff <= qsat ? qtab[SineTableDepth] : qtab[qidx + 1'b1]; end
         ST_SIN_B: begin
            sin_ff <= signed'({2'b0, ta_ff}) + 19'(prod_div30(mprod));
            frac_ff <= 31'h4000_0000 - frac_ff;
         end
         ST_COS_A: begin ta_ff <= qsat ? qtab[SineTableDepth] : qtab[qidx];
            tb_ff <= qsat ? qtab[SineTableDepth] : qtab[qidx + 1'b1];
            tmp_ff <= (pan_depth_ff > 17'd65536) ? ONE_Q16 : signed'({2'b0, pan_depth_ff}); end
         ST_COS_B: cos_ff <= signed'({2'b0, ta_ff}) + 19'(prod_div30(mprod));
         ST_TL: tl_ff <= ONE_Q16 + 19'(q16);
         ST_TR: tr_ff <= ONE_Q16 + 19'(q16);
         ST_OUT_L: rsp_ff.left_out <= sat24(q16);
         ST_OUT_R: rsp_ff.right_out <= sat24(q16);
         default: ;
      endcase
   end

   assign status.first    = req_ff.first_of_frame;
   assign status.div_busy = div_busy;
   assign status.rsp_full = rsp_valid_ff && rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule

// ===== src/lfo_auto_panner_top.sv =====
// channel | direction | handshake       | payload
// req     | in        | valid / stall   | left_sample, right_sample, first_of_frame
// rsp     | out       | valid / stall   | left_out, right_out
// csr     | in        | valid / ready   | index 3 bits, data 32 bits
// a pair without a frame start goes from prep straight to the output steps; a frame start
// first waits on the 30-step gate divider and then runs the shared multiplier path.
// reset is synchronous; config registers, frame state and gains return to their reset values.
// one pair is in work at a time; a stalled result holds the next pair before its
// output steps, so the next pair is taken in and computed meanwhile.
`include "lfo_auto_panner_top_defines.svh"
module lfo_auto_panner_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lap_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lap_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_data
);
   import lap_pkg::*;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lap_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .status(status), .cmd(cmd)
   );

   lap_datapath u_dp (
      .clock(clock), .reset(reset), .req_payload(req_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .cmd(cmd), .status(status), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   `LAP_ASSERT_IMPL(a_busy_stall, clock, reset, cmd.step != ST_IDLE, req_stall)
   `LAP_ASSERT_NEXT(a_out_valid, clock, reset, cmd.step == ST_OUT_R, rsp_valid)
   `LAP_ASSERT_IMPL(a_div_idle, clock, reset, cmd.step == ST_GATE, !status.div_busy)
endmodule
